[rtl/rscd_pkg.sv]
// shared types and constants of the run skip copy delta decoder
package rscd_pkg;

  localparam int unsigned IndexBitsDef  = 24;
  localparam int unsigned QueueDepthDef = 4;

  localparam int unsigned CfgW   = 12;
  localparam int unsigned IdxW   = 24;
  localparam int unsigned LenW   = 15;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TdataW = 56;
  localparam int unsigned TuserW = 2;

  localparam logic [CfgW-1:0]  WidthRst  = 12'd320;
  localparam logic [CfgW-1:0]  HeightRst = 12'd200;
  localparam logic [ByteW-1:0] HdrTag    = 8'h42;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_FILL = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_STOP     = 3'd0,
    ST_FULL     = 3'd1,
    ST_PKT_END  = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_BAD_OP   = 3'd4,
    ST_BAD_REC  = 3'd5,
    ST_BAD_PAD  = 3'd6
  } status_e;

  typedef enum logic [11:0] {
    PH_HDR0  = 12'b0000_0000_0001,
    PH_HDR1  = 12'b0000_0000_0010,
    PH_HDR2  = 12'b0000_0000_0100,
    PH_HDR3  = 12'b0000_0000_1000,
    PH_CMD   = 12'b0000_0001_0000,
    PH_COPY  = 12'b0000_0010_0000,
    PH_SFCNT = 12'b0000_0100_0000,
    PH_SFVAL = 12'b0000_1000_0000,
    PH_LLO   = 12'b0001_0000_0000,
    PH_LHI   = 12'b0010_0000_0000,
    PH_LFVAL = 12'b0100_0000_0000,
    PH_DONE  = 12'b1000_0000_0000
  } phase_e;

  // one queue entry: the pixel result and the end result caused by one byte
  typedef struct packed {
    logic             pix_vld;
    kind_e            pix_kind;
    logic [IdxW-1:0]  pix_index;
    logic [LenW-1:0]  pix_len;
    logic [ByteW-1:0] pix_value;
    logic             end_vld;
    logic [IdxW-1:0]  end_index;
    status_e          end_status;
  } rscd_ent_t;

endpackage

[rtl/rscd_front.sv]
// front end: packet parser, pixel position tracking and result classification
module rscd_front
  import rscd_pkg::*;
#(
  parameter int unsigned INDEX_BITS = IndexBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [ByteW-1:0]      byte_i,
  input  logic                  last_i,
  input  logic [INDEX_BITS:0]   lim_i,
  output logic                  push_o,
  output rscd_ent_t             ent_o
);

  localparam int unsigned PosW = INDEX_BITS + 1;

  phase_e            phase_q, phase_d, phase_n;
  logic [LenW-1:0]   count_q, count_d, count_n;
  logic [ByteW-1:0]  low_q, low_d;
  logic [PosW-1:0]   pos_q, pos_d, pos_n;

  logic              run_go;
  logic [LenW-1:0]   run_c, run_len;
  logic [PosW-1:0]   run_sum, run_gap, run_pos;
  logic              room_ok, run_over, run_fin;
  logic [PosW-1:0]   lit_pos;
  logic              lit_end;
  logic [13:0]       long_c;
  logic              fin;
  status_e           fin_st;
  rscd_ent_t         ent;

  assign long_c = {byte_i[5:0], low_q};

  // count of the run that this byte starts, if any
  always_comb begin
    run_go   = 1'b0;
    run_c    = '0;
    case (phase_q)
      PH_CMD: begin
        if (byte_i[7] && byte_i[6:0] != '0) begin
          run_go = 1'b1;
          run_c  = {8'd0, byte_i[6:0]};
        end
      end
      PH_SFVAL, PH_LFVAL: begin
        run_go   = count_q != '0;
        run_c    = count_q;
      end
      PH_LHI: begin
        // long skip: type 1 adds 0x4000, which is bit 14 of the count
        if (long_c != '0 && !byte_i[7]) begin
          run_go = 1'b1;
          run_c  = {byte_i[6], long_c};
        end
      end
      default: ;
    endcase
  end

  // clipping against the frame limit, all compares side by side
  assign room_ok  = pos_q < lim_i;
  assign run_sum  = pos_q + PosW'(run_c);
  assign run_over = run_sum >= lim_i;
  assign run_gap  = lim_i - pos_q;
  assign run_fin  = !room_ok || run_over;
  assign run_len  = !room_ok ? '0 : (run_over ? LenW'(run_gap) : run_c);
  assign run_pos  = !room_ok ? pos_q : (run_over ? lim_i : run_sum);
  assign lit_pos  = pos_q + 1'b1;
  assign lit_end  = lit_pos >= lim_i;

  always_comb begin
    phase_n = phase_q;
    count_n = count_q;
    low_d   = low_q;
    pos_n   = pos_q;
    ent     = '0;
    fin     = 1'b0;
    fin_st  = ST_FULL;
    case (phase_q)
      PH_HDR0: begin
        if (byte_i != HdrTag) begin
          fin    = 1'b1;
          fin_st = ST_BAD_REC;
        end else begin
          phase_n = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (byte_i != '0) begin
          fin    = 1'b1;
          fin_st = ST_BAD_PAD;
        end else begin
          phase_n = PH_HDR2;
        end
      end
      PH_HDR2: phase_n = PH_HDR3;
      PH_HDR3: phase_n = PH_CMD;
      PH_CMD: begin
        if (byte_i[6:0] != '0) begin
          if (byte_i[7]) begin
            pos_n = run_pos;
            fin   = run_fin;
          end else begin
            count_n = {8'd0, byte_i[6:0]};
            phase_n = PH_COPY;
          end
        end else begin
          phase_n = byte_i[7] ? PH_LLO : PH_SFCNT;
        end
      end
      PH_COPY: begin
        if (!room_ok) begin
          fin = 1'b1;
        end else begin
          ent.pix_vld   = 1'b1;
          ent.pix_kind  = KIND_LIT;
          ent.pix_index = IdxW'(pos_q);
          ent.pix_len   = LenW'(1);
          ent.pix_value = byte_i;
          pos_n         = lit_pos;
          count_n       = count_q - 1'b1;
          if (lit_end) begin
            fin = 1'b1;
          end else if (count_q == LenW'(1)) begin
            phase_n = PH_CMD;
          end
        end
      end
      PH_SFCNT: begin
        count_n = {7'd0, byte_i};
        phase_n = PH_SFVAL;
      end
      PH_SFVAL, PH_LFVAL: begin
        phase_n = PH_CMD;
        if (run_go) begin
          pos_n         = run_pos;
          fin           = run_fin;
          ent.pix_vld   = room_ok;
          ent.pix_kind  = KIND_FILL;
          ent.pix_index = IdxW'(pos_q);
          ent.pix_len   = run_len;
          ent.pix_value = byte_i;
        end
      end
      PH_LLO: begin
        low_d   = byte_i;
        phase_n = PH_LHI;
      end
      PH_LHI: begin
        phase_n = PH_CMD;
        if (long_c == '0) begin
          if (byte_i[7:6] == 2'd0) begin
            fin    = 1'b1;
            fin_st = ST_STOP;
          end else if (byte_i[7:6] == 2'd2) begin
            fin    = 1'b1;
            fin_st = ST_BAD_OP;
          end
        end else if (run_go) begin
          pos_n = run_pos;
          fin   = run_fin;
        end else begin
          count_n = {1'b0, long_c};
          phase_n = byte_i[6] ? PH_LFVAL : PH_COPY;
        end
      end
      PH_DONE: ;
      default: phase_n = PH_DONE;
    endcase

    if (fin) begin
      phase_n = PH_DONE;
    end
    ent.end_vld    = fin;
    ent.end_status = fin_st;

    // packet end closes a frame that has not ended yet
    if (last_i && phase_n != PH_DONE) begin
      ent.end_vld    = 1'b1;
      ent.end_status = (phase_n == PH_COPY && count_n != '0) ? ST_TRUNC : ST_PKT_END;
    end
    ent.end_index = IdxW'(pos_n);

    phase_d = last_i ? PH_HDR0 : phase_n;
    pos_d   = last_i ? '0 : pos_n;
    count_d = last_i ? '0 : count_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      count_q <= '0;
      low_q   <= '0;
      pos_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      low_q   <= low_d;
      pos_q   <= pos_d;
    end
  end

  assign push_o = fire_i && (ent.pix_vld || ent.end_vld);
  assign ent_o  = ent;

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> phase_q == PH_HDR0 && pos_q == '0)
    else $error("packet end did not return the parser to the header");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && phase_q == PH_DONE |-> !ent_o.pix_vld && !ent_o.end_vld)
    else $error("result produced after the frame end");

  a_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && ent_o.end_vld && !last_i |=> phase_q == PH_DONE)
    else $error("frame end emitted but parser still running");

endmodule

[rtl/rscd_queue.sv]
// short queue of classified results between front and back
module rscd_queue
  import rscd_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rscd_ent_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output rscd_ent_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rscd_ent_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/rscd_back.sv]
// back end: output register that sends the pixel result, then the end result
module rscd_back
  import rscd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  rscd_ent_t         q_data_i,
  output logic              q_pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [TdataW-1:0] m_tdata_o,
  output logic [TuserW-1:0] m_tuser_o
);

  rscd_ent_t cur_q, cur_d;
  logic      pix_pend_q, pix_pend_d;
  logic      end_pend_q, end_pend_d;
  logic      take, final_beat, load;

  assign m_tvalid_o = pix_pend_q || end_pend_q;
  assign take       = m_tvalid_o && m_tready_i;
  // the beat on the port is the last one of the current entry
  assign final_beat = !(pix_pend_q && end_pend_q);
  assign load       = !q_empty_i && (!m_tvalid_o || (take && final_beat));
  assign q_pop_o    = load;

  always_comb begin
    cur_d      = cur_q;
    pix_pend_d = pix_pend_q;
    end_pend_d = end_pend_q;
    if (load) begin
      cur_d      = q_data_i;
      pix_pend_d = q_data_i.pix_vld;
      end_pend_d = q_data_i.end_vld;
    end else if (take) begin
      if (final_beat) begin
        end_pend_d = 1'b0;
      end
      pix_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_pend_q <= 1'b0;
      end_pend_q <= 1'b0;
    end else begin
      pix_pend_q <= pix_pend_d;
      end_pend_q <= end_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    if (pix_pend_q) begin
      m_tuser_o = cur_q.pix_kind;
      m_tdata_o = {6'd0, ST_STOP, cur_q.pix_value, cur_q.pix_len, cur_q.pix_index};
    end else begin
      m_tuser_o = KIND_END;
      m_tdata_o = {6'd0, cur_q.end_status, ByteW'(0), LenW'(0), cur_q.end_index};
    end
  end

endmodule

[rtl/run_skip_copy_delta_decoder_top.sv]
// A byte's result is written into the queue, then loaded into the output register, and then offered.
// Throughput: one packet byte per cycle unless the queue is full; a byte with both a pixel and
// an end result holds the output for two beats; the front may run QUEUE_DEPTH entries ahead.
// Position clipping is one add and compare per byte in the front parser.
// Reset: asynchronous, active low; parser waits for a record header, position 0, registers
// return to 320 by 200, queue and output are empty.
module run_skip_copy_delta_decoder_top
  import rscd_pkg::*;
#(
  parameter int unsigned INDEX_BITS  = IndexBitsDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // apb configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic              s_axis_tlast,
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,  // [23:0] pixel_index, [38:24] run_length,
                                           // [46:39] pixel_value, [49:47] end_status
  output logic [TuserW-1:0] m_axis_tuser   // [1:0] kind
);

  localparam int unsigned     PosW       = INDEX_BITS + 1;
  localparam logic [24:0]     LimCap     = 25'(1) << INDEX_BITS;
  localparam logic [24:0]     LimRstFull = 25'(WidthRst) * 25'(HeightRst);
  localparam logic [PosW-1:0] LimRst     =
    PosW'((LimRstFull >= LimCap) ? LimCap : LimRstFull);

  logic [CfgW-1:0]   width_q, width_d, height_q, height_d;
  logic [CfgW-1:0]   mul_a, mul_b;
  logic [23:0]       prod;
  logic [24:0]       lim_full;
  logic [PosW-1:0]   lim_q, lim_d;
  logic              wr_en;
  reg_e              reg_sel;

  logic              fire, push, q_full, q_empty, q_pop;
  rscd_ent_t         ent, q_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (reg_sel)
        REG_WIDTH:  width_d  = pwdata[CfgW-1:0];
        REG_HEIGHT: height_d = pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  // the limit follows the written value in the same edge, so a byte right after a write sees it
  assign mul_a    = width_d;
  assign mul_b    = height_d;
  assign prod     = mul_a * mul_b;
  assign lim_full = ({1'b0, prod} >= LimCap) ? LimCap : {1'b0, prod};
  assign lim_d    = PosW'(lim_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      lim_q    <= LimRst;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      lim_q    <= lim_d;
    end
  end

  assign s_axis_tready = !q_full;
  assign fire          = s_axis_tvalid && s_axis_tready;

  rscd_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .lim_i  (lim_q),
    .push_o (push),
    .ent_o  (ent)
  );

  rscd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ent),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  rscd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

[tb/tb_run_skip_copy_delta_decoder_top.sv]
// self-checking testbench for the run skip copy delta decoder
module tb_run_skip_copy_delta_decoder_top
  import rscd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e            kind;
    logic [IdxW-1:0]  pix;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] value;
    status_e          status;
  } dec_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [ByteW-1:0]  s_axis_tdata;  // [7:0] in_byte
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [TdataW-1:0] m_axis_tdata;  // [23:0] pixel_index, [38:24] run_length,
                                    // [46:39] pixel_value, [49:47] end_status
  logic [TuserW-1:0] m_axis_tuser;  // [1:0] kind

  // decoder state as the testbench sees it
  logic [CfgW-1:0]  cfg_width  = WidthRst;
  logic [CfgW-1:0]  cfg_height = HeightRst;
  phase_e           dec_phase  = PH_HDR0;
  logic [LenW-1:0]  dec_left   = '0;
  logic [ByteW-1:0] dec_lo     = '0;
  int unsigned      dec_pos    = 0;
  bit               dec_done   = 1'b0;

  dec_result_t owed_results[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;

  run_skip_copy_delta_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_run_skip_copy_delta_decoder_top failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned frame_limit();
    int unsigned area;
    int unsigned cap;
    area = int'(cfg_width) * int'(cfg_height);
    cap  = 32'd1 << IndexBitsDef;
    return (area < cap) ? area : cap;
  endfunction

  function automatic void owe(kind_e k, int unsigned p, int unsigned l,
                              logic [ByteW-1:0] v, status_e s);
    dec_result_t r;
    r.kind   = k;
    r.pix    = p[IdxW-1:0];
    r.len    = l[LenW-1:0];
    r.value  = v;
    r.status = s;
    owed_results.push_back(r);
  endfunction

  function automatic void end_frame(status_e s);
    dec_done  = 1'b1;
    dec_phase = PH_DONE;
    owe(KIND_END, dec_pos, 0, '0, s);
  endfunction

  // skip or fill, clipped at the frame end
  function automatic void advance(int unsigned cnt, bit is_fill, logic [ByteW-1:0] v);
    int unsigned lim;
    int unsigned room;
    int unsigned r;
    if (cnt == 0) return;
    lim  = frame_limit();
    room = (dec_pos < lim) ? lim - dec_pos : 0;
    r    = (cnt < room) ? cnt : room;
    if (is_fill && r > 0) owe(KIND_FILL, dec_pos, r, v, ST_STOP);
    dec_pos += r;
    if (dec_pos >= lim) end_frame(ST_FULL);
  endfunction

  function automatic void decode_byte(logic [ByteW-1:0] b, logic last);
    int unsigned lim;
    int unsigned cnt;
    logic [15:0] word;
    logic [1:0]  ltype;
    if (!dec_done) begin
      case (dec_phase)
        PH_HDR0: begin
          if (b != HdrTag) end_frame(ST_BAD_REC);
          else dec_phase = PH_HDR1;
        end
        PH_HDR1: begin
          if (b != 8'h00) end_frame(ST_BAD_PAD);
          else dec_phase = PH_HDR2;
        end
        PH_HDR2: dec_phase = PH_HDR3;
        PH_HDR3: dec_phase = PH_CMD;
        PH_CMD: begin
          cnt = b[6:0];
          if (cnt != 0) begin
            if (b[7]) begin
              advance(cnt, 1'b0, '0);
            end else begin
              dec_left  = cnt[LenW-1:0];
              dec_phase = PH_COPY;
            end
          end else begin
            dec_phase = b[7] ? PH_LLO : PH_SFCNT;
          end
        end
        PH_COPY: begin
          lim = frame_limit();
          if (dec_pos >= lim) begin
            end_frame(ST_FULL);
          end else begin
            owe(KIND_LIT, dec_pos, 1, b, ST_STOP);
            dec_pos++;
            dec_left = dec_left - 1'b1;
            if (dec_pos >= lim) end_frame(ST_FULL);
            else if (dec_left == 0) dec_phase = PH_CMD;
          end
        end
        PH_SFCNT: begin
          dec_left  = b;
          dec_phase = PH_SFVAL;
        end
        PH_SFVAL, PH_LFVAL: begin
          dec_phase = PH_CMD;
          advance(dec_left, 1'b1, b);
        end
        PH_LLO: begin
          dec_lo    = b;
          dec_phase = PH_LHI;
        end
        PH_LHI: begin
          word      = {b, dec_lo};
          cnt       = word[13:0];
          ltype     = word[15:14];
          dec_phase = PH_CMD;
          if (cnt == 0) begin
            // type 1 and 3 with zero count do nothing
            if (ltype == 2'd0) end_frame(ST_STOP);
            else if (ltype == 2'd2) end_frame(ST_BAD_OP);
          end else if (ltype == 2'd0) begin
            advance(cnt, 1'b0, '0);
          end else if (ltype == 2'd1) begin
            advance(cnt + 32'h4000, 1'b0, '0);
          end else if (ltype == 2'd2) begin
            dec_left  = cnt[LenW-1:0];
            dec_phase = PH_COPY;
          end else begin
            dec_left  = cnt[LenW-1:0];
            dec_phase = PH_LFVAL;
          end
        end
        default: begin
          dec_done  = 1'b1;
          dec_phase = PH_DONE;
        end
      endcase
    end
    if (last) begin
      if (!dec_done)
        end_frame((dec_phase == PH_COPY && dec_left != 0) ? ST_TRUNC : ST_PKT_END);
      dec_phase = PH_HDR0;
      dec_pos   = 0;
      dec_left  = '0;
      dec_done  = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(string what, longint unsigned got,
                               longint unsigned want);
    if (mismatch_count < 40)
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    dec_result_t got;
    dec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind   = kind_e'(m_axis_tuser);
      got.pix    = m_axis_tdata[23:0];
      got.len    = m_axis_tdata[38:24];
      got.value  = m_axis_tdata[46:39];
      got.status = status_e'(m_axis_tdata[49:47]);
      if (owed_results.size() == 0) begin
        flag_mismatch("result beat with none owed, kind", got.kind, 0);
      end else begin
        want = owed_results.pop_front();
        if (got.kind !== want.kind) flag_mismatch("kind", got.kind, want.kind);
        if (got.pix !== want.pix) flag_mismatch("pixel_index", got.pix, want.pix);
        if (got.len !== want.len) flag_mismatch("run_length", got.len, want.len);
        if (got.value !== want.value) flag_mismatch("pixel_value", got.value, want.value);
        if (got.status !== want.status)
          flag_mismatch("end_status", got.status, want.status);
      end
    end
  end

  // receiver stalls in spans of changing character
  initial begin
    int unsigned mode;
    int unsigned span;
    m_axis_tready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 30) : $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 4) == 0);
          default: m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, last);
    burst_left--;
  endtask

  task automatic send_bytes(input logic [ByteW-1:0] pkt[$], input bit close);
    foreach (pkt[i]) send_byte(pkt[i], close && (i == pkt.size() - 1));
  endtask

  // wait until every owed beat is out and the pipeline has emptied
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (2 * QueueDepthDef + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [CfgW-1:0] val);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {20'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (r == REG_WIDTH) cfg_width = val;
    else cfg_height = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_header_checks();
    send_bytes('{8'h41, HdrTag, 8'h00, 8'h11}, 1'b1);  // wrong record tag, rest ignored
    send_bytes('{HdrTag, 8'h80, 8'h00}, 1'b1);         // nonzero padding
    send_bytes('{HdrTag, 8'h00, 8'hFF}, 1'b1);         // packet ends inside header
  endtask

  task automatic test_commands();
    send_bytes('{HdrTag, 8'h00, 8'hA5, 8'h5A,
                 8'h03, 8'h00, 8'hFF, 8'h5A,           // short copy of three
                 8'h85,                                // short skip
                 8'h00, 8'h00, 8'h77,                  // short fill of zero pixels
                 8'h00, 8'hFF, 8'h80,                  // short fill of 255
                 8'h80, 8'h00, 8'h01,                  // long skip
                 8'h80, 8'h01, 8'h40,                  // long skip plus 0x4000
                 8'h80, 8'h02, 8'h80, 8'h7F, 8'h01,    // long copy
                 8'h80, 8'hFF, 8'hFF, 8'hC3,           // long fill of 0x3fff
                 8'h80, 8'h00, 8'h40,                  // no-op
                 8'h80, 8'h00, 8'hC0,                  // no-op
                 8'h80, 8'h00, 8'h80,                  // unknown opcode
                 8'h12}, 1'b1);
    send_bytes('{HdrTag, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'hFF}, 1'b1);
  endtask

  task automatic test_frame_full();
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd2);
    // fill clipped at the frame end
    send_bytes('{HdrTag, 8'h00, 8'h00, 8'h00, 8'h85, 8'h00, 8'h09, 8'hEE, 8'h33}, 1'b1);
    // literal on the last pixel
    send_bytes('{HdrTag, 8'h00, 8'h00, 8'h00, 8'h85, 8'h01, 8'hAA, 8'h01}, 1'b1);
    drain_results();
    write_reg(REG_WIDTH, 12'd0);
    send_bytes('{HdrTag, 8'h00, 8'h00, 8'h00, 8'h01, 8'h77, 8'h00}, 1'b1);
    // registers lowered in the middle of a frame
    drain_results();
    write_reg(REG_WIDTH, 12'd10);
    write_reg(REG_HEIGHT, 12'd10);
    send_bytes('{HdrTag, 8'h00, 8'h00, 8'h00, 8'h80, 8'h32, 8'h00}, 1'b0);
    drain_results();
    write_reg(REG_WIDTH, 12'd2);
    send_bytes('{8'h00, 8'h03, 8'h44, 8'h55}, 1'b1);
  endtask

  task automatic test_packet_end();
    drain_results();
    write_reg(REG_WIDTH, 12'd4095);
    write_reg(REG_HEIGHT, 12'd4095);
    // long copy of 0x3fff cut short
    send_bytes('{HdrTag, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hBF,
                 8'h01, 8'h02, 8'h03}, 1'b1);
    // finished copy, then a fill command left open
    send_bytes('{HdrTag, 8'h00, 8'h00, 8'h00, 8'h02, 8'h10, 8'h20, 8'h00, 8'h05}, 1'b1);
  endtask

  task automatic send_random_packet(output int unsigned n_sent);
    logic [ByteW-1:0] pkt[$];
    int unsigned      cnt;
    int unsigned      cut;
    logic [1:0]       ltype;
    if ($urandom_range(0, 99) < 10) begin
      // noise and broken headers
      repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 1) pkt[0] = HdrTag;
    end else begin
      pkt = '{HdrTag, 8'h00, 8'($urandom), 8'($urandom)};
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 8))
          0, 1: begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            pkt.push_back(8'(cnt));
            repeat (cnt) pkt.push_back(8'($urandom));
          end
          2: pkt.push_back(8'h80 | 8'($urandom_range(1, 127)));
          3: begin
            pkt.push_back(8'h00);
            pkt.push_back(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom));
            pkt.push_back(8'($urandom));
          end
          4, 5: begin
            cnt   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16383)
                                                : $urandom_range(1, 64);
            ltype = 2'($urandom_range(0, 1));
            pkt.push_back(8'h80);
            pkt.push_back(cnt[7:0]);
            pkt.push_back({ltype, cnt[13:8]});
          end
          6: begin
            cnt = $urandom_range(1, 6);
            pkt.push_back(8'h80);
            pkt.push_back(8'(cnt));
            pkt.push_back(8'h80);
            repeat (cnt) pkt.push_back(8'($urandom));
          end
          7: begin
            cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16383)
                                              : $urandom_range(1, 64);
            pkt.push_back(8'h80);
            pkt.push_back(cnt[7:0]);
            pkt.push_back({2'b11, cnt[13:8]});
            pkt.push_back(8'($urandom));
          end
          default: begin
            // zero count long forms: stop, no-op, unknown
            pkt.push_back(8'h80);
            pkt.push_back(8'h00);
            pkt.push_back({2'($urandom_range(0, 3)), 6'h00});
          end
        endcase
      end
      if ($urandom_range(0, 1) == 1) begin
        pkt.push_back(8'h80);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
      end
      if ($urandom_range(0, 3) == 0) pkt.push_back(8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
    end
    send_bytes(pkt, 1'b1);
    n_sent = pkt.size();
  endtask

  task automatic test_random_packets();
    int unsigned sent;
    int unsigned n;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(REG_WIDTH, 12'd1);
          write_reg(REG_HEIGHT, 12'd1);
        end
        1: begin
          write_reg(REG_WIDTH, 12'd4095);
          write_reg(REG_HEIGHT, 12'd4095);
        end
        7: begin
          write_reg(REG_WIDTH, 12'($urandom_range(1, 4095)));
          write_reg(REG_HEIGHT, 12'($urandom_range(1, 4095)));
        end
        default: begin
          write_reg(REG_WIDTH, 12'($urandom_range(1, 40)));
          write_reg(REG_HEIGHT, 12'($urandom_range(1, 24)));
        end
      endcase
      sent = 0;
      while (sent < 120) begin
        send_random_packet(n);
        sent += n;
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_checks();
    test_commands();
    test_frame_full();
    test_packet_end();
    test_random_packets();

    s_axis_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_run_skip_copy_delta_decoder_top passed");
    end else begin
      $display("tb_run_skip_copy_delta_decoder_top failed");
    end
    $finish;
  end

endmodule
